/* rtl/core/mnd_pkg.sv */
package mnd_pkg;

  // Width of the range register and of the ranges carried with each job.
  localparam int unsigned RANGE_W = 2;

  // Reset value of the detect range register.
  localparam logic [RANGE_W-1:0] DETECT_RANGE_RESET = 2'd2;

  // Register index of detect_range within the register file.
  localparam logic REG_DETECT_RANGE = 1'b0;

  // Range, previous range and previous-set valid bit travel with each job.
  localparam int unsigned JOB_EXTRA_W = 2 * RANGE_W + 1;

  // Depth of the job queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Walk offsets span -3 .. +3.
  typedef logic signed [2:0] off_t;

  // Event codes of a reported cell.
  localparam logic EV_ENTER = 1'b0;
  localparam logic EV_LEFT  = 1'b1;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_WALK,
    B_FLUSH
  } back_state_e;

  // Queue status seen by the front, the back and the checks.
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  // Back end status seen by the checks.
  typedef struct packed {
    logic busy;
    logic holding;
    logic done;
  } bk_status_t;

endpackage

/* rtl/core/manhattan_neighborhood_diff.sv */
// Diamond neighborhood tracker. Each input transaction carries the grid cell
// now holding a tracked object; when it differs from the remembered centre, the
// block reports every cell of the new diamond (Manhattan radius detect_range,
// saturated to MAX_RANGE) not in the remembered diamond as entered, then every
// cell of the remembered diamond no longer covered as left, each diamond walked
// in raster order with dx outer and dy inner, and marks the final result last.
// Coordinates wrap modulo 2^COORD_BITS. A front end takes one input each cycle
// while the job queue is not full, drops repeats of the remembered centre and
// queues up to two jobs; the back end walks one offset per cycle unless the
// result side stalls, and skips the second walk on the first job. The range
// register sits at byte address 0 and takes effect at the next centre change.
module manhattan_neighborhood_diff #(
  parameter int unsigned MAX_RANGE  = 3,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_BITS-1:0]  center_x_i,
  input  logic signed [COORD_BITS-1:0]  center_y_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [COORD_BITS-1:0]  cell_x_o,
  output logic signed [COORD_BITS-1:0]  cell_y_o,
  output logic                          event_kind_o,
  output logic                          last_o,
  // Register port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import mnd_pkg::*;

  localparam int unsigned JOB_W = 6 * COORD_BITS + JOB_EXTRA_W;

  logic             push;
  logic             pop;
  logic [JOB_W-1:0] job_wr;
  logic [JOB_W-1:0] job_rd;
  q_status_t        q_status;
  bk_status_t       bk_status;

  // Front end: register port, repeat filter and remembered diamond.
  mnd_front #(
    .COORD_BITS (COORD_BITS),
    .MAX_RANGE  (MAX_RANGE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (job_wr)
  );

  // Job queue between the two halves.
  mnd_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (job_wr),
    .pop_i    (pop),
    .data_o   (job_rd),
    .status_o (q_status)
  );

  // Back end: the two diamond walks and the result register.
  mnd_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_rd),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_x_o     (cell_x_o),
    .cell_y_o     (cell_y_o),
    .event_kind_o (event_kind_o),
    .last_o       (last_o),
    .status_o     (bk_status)
  );

  // The back end only works on a job that is still in the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.busy |-> !q_status.empty)
    else $error("back end busy with an empty job queue");

  // Finishing a job leaves no cell waiting in the hold register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.done |=> !bk_status.holding)
    else $error("cell left in hold register after job completion");

  // The queue never overfills, and a push is never made while it is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_status.count <= QCNT_W'(QUEUE_DEPTH)) && !(push && q_status.full))
    else $error("job queue overflow");

endmodule

/* rtl/core/mnd_queue.sv */
module mnd_queue #(
  parameter int unsigned WIDTH = 101
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [WIDTH-1:0]    data_i,
  input  logic                pop_i,
  output logic [WIDTH-1:0]    data_o,
  output mnd_pkg::q_status_t  status_o
);
  import mnd_pkg::*;

  logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = QCNT_W'(count_q + 1'b1);
    end else if (pop_i && !push_i) begin
      count_d = QCNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign status_o.count = count_q;

endmodule

/* rtl/core/mnd_front.sv */
module mnd_front #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned MAX_RANGE  = 3
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // Input channel.
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic signed [COORD_BITS-1:0]               center_x_i,
  input  logic signed [COORD_BITS-1:0]               center_y_i,
  // Register port.
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [2:0]                                 paddr,
  input  logic [31:0]                                pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready,
  // Job queue write side.
  input  mnd_pkg::q_status_t                         q_status_i,
  output logic                                       push_o,
  output logic [6*COORD_BITS+mnd_pkg::JOB_EXTRA_W-1:0] job_o
);
  import mnd_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] pcx;
    logic [COORD_BITS-1:0] pcy;
    logic [COORD_BITS-1:0] dcx;
    logic [COORD_BITS-1:0] dcy;
    logic [RANGE_W-1:0]    r;
    logic [RANGE_W-1:0]    pr;
    logic                  pvalid;
  } job_t;

  logic [RANGE_W-1:0]    detect_range_q, detect_range_d;
  logic [COORD_BITS-1:0] prev_cx_q, prev_cx_d;
  logic [COORD_BITS-1:0] prev_cy_q, prev_cy_d;
  logic [RANGE_W-1:0]    prev_r_q, prev_r_d;
  logic                  prev_valid_q, prev_valid_d;

  logic                  cfg_write;
  logic                  accept;
  logic                  same_center;
  logic [RANGE_W-1:0]    r_sat;
  job_t                  job;

  // Register port: always ready, one register at word zero.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_DETECT_RANGE) ? {30'd0, detect_range_q} : 32'd0;

  always_comb begin
    detect_range_d = detect_range_q;
    if (cfg_write && (paddr[2] == REG_DETECT_RANGE)) begin
      detect_range_d = pwdata[RANGE_W-1:0];
    end
  end

  // Classification: a repeat of the remembered centre is dropped here.
  assign in_stall_o  = q_status_i.full;
  assign accept      = in_valid_i && !in_stall_o;
  assign same_center = (center_x_i == prev_cx_q) && (center_y_i == prev_cy_q);
  assign push_o      = accept && !same_center;
  assign r_sat       = (detect_range_q > RANGE_W'(MAX_RANGE)) ? RANGE_W'(MAX_RANGE)
                                                              : detect_range_q;

  // Job for the back end, with the centre offset worked out once.
  always_comb begin
    job.cx     = center_x_i;
    job.cy     = center_y_i;
    job.pcx    = prev_cx_q;
    job.pcy    = prev_cy_q;
    job.dcx    = center_x_i - prev_cx_q;
    job.dcy    = center_y_i - prev_cy_q;
    job.r      = r_sat;
    job.pr     = prev_r_q;
    job.pvalid = prev_valid_q;
  end
  assign job_o = job;

  // The remembered diamond moves as soon as a job is queued.
  always_comb begin
    prev_cx_d    = prev_cx_q;
    prev_cy_d    = prev_cy_q;
    prev_r_d     = prev_r_q;
    prev_valid_d = prev_valid_q;
    if (push_o) begin
      prev_cx_d    = center_x_i;
      prev_cy_d    = center_y_i;
      prev_r_d     = r_sat;
      prev_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_range_q <= DETECT_RANGE_RESET;
      prev_cx_q      <= '0;
      prev_cy_q      <= '0;
      prev_r_q       <= '0;
      prev_valid_q   <= 1'b0;
    end else begin
      detect_range_q <= detect_range_d;
      prev_cx_q      <= prev_cx_d;
      prev_cy_q      <= prev_cy_d;
      prev_r_q       <= prev_r_d;
      prev_valid_q   <= prev_valid_d;
    end
  end

endmodule

/* rtl/core/mnd_back.sv */
module mnd_back #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  // Job queue read side.
  input  logic [6*COORD_BITS+mnd_pkg::JOB_EXTRA_W-1:0] job_i,
  input  mnd_pkg::q_status_t                           q_status_i,
  output logic                                         pop_o,
  // Result channel.
  output logic                                         out_valid_o,
  input  logic                                         out_stall_i,
  output logic signed [COORD_BITS-1:0]                 cell_x_o,
  output logic signed [COORD_BITS-1:0]                 cell_y_o,
  output logic                                         event_kind_o,
  output logic                                         last_o,
  output mnd_pkg::bk_status_t                          status_o
);
  import mnd_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] pcx;
    logic [COORD_BITS-1:0] pcy;
    logic [COORD_BITS-1:0] dcx;
    logic [COORD_BITS-1:0] dcy;
    logic [RANGE_W-1:0]    r;
    logic [RANGE_W-1:0]    pr;
    logic                  pvalid;
  } job_t;

  back_state_e           state_q, state_d;
  logic                  phase_q, phase_d;
  off_t                  dx_q, dx_d;
  off_t                  dy_q, dy_d;
  logic                  hold_valid_q, hold_valid_d;
  logic [COORD_BITS-1:0] hold_x_q, hold_x_d;
  logic [COORD_BITS-1:0] hold_y_q, hold_y_d;
  logic                  hold_kind_q, hold_kind_d;
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] out_x_q, out_x_d;
  logic [COORD_BITS-1:0] out_y_q, out_y_d;
  logic                  out_kind_q, out_kind_d;
  logic                  out_last_q, out_last_d;

  job_t                  job;
  logic [RANGE_W-1:0]    walk_r;
  logic [RANGE_W-1:0]    oth_r;
  off_t                  walk_pos;
  logic [COORD_BITS-1:0] dx_ext, dy_ext;
  logic [COORD_BITS-1:0] diff_x, diff_y;
  logic [COORD_BITS-1:0] mag_x, mag_y;
  logic [COORD_BITS:0]   dist_oth;
  logic                  in_other;
  logic [1:0]            ax, ay;
  logic [2:0]            dist_walk;
  logic                  in_walk;
  logic                  emit_c;
  logic [COORD_BITS-1:0] cell_x_c, cell_y_c;
  logic                  out_free;
  logic                  advance;

  assign job = job_t'(job_i);

  // Phase zero walks the new diamond, phase one the remembered one.
  assign walk_r   = phase_q ? job.pr : job.r;
  assign oth_r    = phase_q ? job.r : job.pr;
  assign walk_pos = off_t'({1'b0, walk_r});

  // Offset from the other diamond's center, on the wrapped grid.
  assign dx_ext = {{(COORD_BITS-3){dx_q[2]}}, dx_q};
  assign dy_ext = {{(COORD_BITS-3){dy_q[2]}}, dy_q};
  assign diff_x = phase_q ? (dx_ext - job.dcx) : (job.dcx + dx_ext);
  assign diff_y = phase_q ? (dy_ext - job.dcy) : (job.dcy + dy_ext);
  assign mag_x  = diff_x[COORD_BITS-1] ? (~diff_x + 1'b1) : diff_x;
  assign mag_y  = diff_y[COORD_BITS-1] ? (~diff_y + 1'b1) : diff_y;
  assign dist_oth = {1'b0, mag_x} + {1'b0, mag_y};
  assign in_other = (dist_oth <= (COORD_BITS+1)'(oth_r));

  // Offset lies within the diamond being walked.
  assign ax        = dx_q[2] ? 2'(-dx_q) : dx_q[1:0];
  assign ay        = dy_q[2] ? 2'(-dy_q) : dy_q[1:0];
  assign dist_walk = {1'b0, ax} + {1'b0, ay};
  assign in_walk   = (dist_walk <= {1'b0, walk_r});

  assign emit_c   = in_walk && (phase_q ? !in_other : (!job.pvalid || !in_other));
  assign cell_x_c = (phase_q ? job.pcx : job.cx) + dx_ext;
  assign cell_y_c = (phase_q ? job.pcy : job.cy) + dy_ext;

  // A held cell is released only when the output register can take it.
  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = !(emit_c && hold_valid_q) || out_free;

  // Walk sequencer. The newest cell waits in the hold register until the
  // next one is found or the walk ends, so that it can be marked last.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    hold_valid_d = hold_valid_q;
    hold_x_d    = hold_x_q;
    hold_y_d    = hold_y_q;
    hold_kind_d = hold_kind_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    pop_o       = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = B_WALK;
          phase_d = 1'b0;
          dx_d    = off_t'(-$signed({1'b0, job.r}));
          dy_d    = off_t'(-$signed({1'b0, job.r}));
        end
      end
      B_WALK: begin
        if (advance) begin
          if (emit_c) begin
            if (hold_valid_q) begin
              out_valid_d = 1'b1;
              out_x_d     = hold_x_q;
              out_y_d     = hold_y_q;
              out_kind_d  = hold_kind_q;
              out_last_d  = 1'b0;
            end
            hold_valid_d = 1'b1;
            hold_x_d     = cell_x_c;
            hold_y_d     = cell_y_c;
            hold_kind_d  = phase_q ? EV_LEFT : EV_ENTER;
          end
          if (dy_q == walk_pos) begin
            dy_d = off_t'(-$signed({1'b0, walk_r}));
            if (dx_q == walk_pos) begin
              if (!phase_q && job.pvalid) begin
                phase_d = 1'b1;
                dx_d    = off_t'(-$signed({1'b0, job.pr}));
                dy_d    = off_t'(-$signed({1'b0, job.pr}));
              end else begin
                state_d = B_FLUSH;
              end
            end else begin
              dx_d = off_t'(dx_q + 3'sd1);
            end
          end else begin
            dy_d = off_t'(dy_q + 3'sd1);
          end
        end
      end
      B_FLUSH: begin
        if (!hold_valid_q) begin
          pop_o   = 1'b1;
          state_d = B_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_x_d      = hold_x_q;
          out_y_d      = hold_y_q;
          out_kind_d   = hold_kind_q;
          out_last_d   = 1'b1;
          hold_valid_d = 1'b0;
          pop_o        = 1'b1;
          state_d      = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      phase_q      <= 1'b0;
      dx_q         <= '0;
      dy_q         <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      dx_q         <= dx_d;
      dy_q         <= dy_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    hold_x_q    <= hold_x_d;
    hold_y_q    <= hold_y_d;
    hold_kind_q <= hold_kind_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cell_x_o     = out_x_q;
  assign cell_y_o     = out_y_q;
  assign event_kind_o = out_kind_q;
  assign last_o       = out_last_q;

  assign status_o.busy    = (state_q != B_IDLE);
  assign status_o.holding = hold_valid_q;
  assign status_o.done    = pop_o;

endmodule

/* test/tb_manhattan_neighborhood_diff.sv */
`timescale 1ns / 100ps

module tb_manhattan_neighborhood_diff;
  import mnd_pkg::*;

  localparam int unsigned COORD_W      = 16;
  localparam int unsigned MAX_RANGE    = 3;
  localparam logic [2:0]  RANGE_ADDR   = 3'(REG_DETECT_RANGE) * 3'd4;
  localparam int          DRAIN_CYCLES = 150;
  localparam int          WATCHDOG_MAX = 4000;

  // One reported cell as the block should emit it.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               kind;
    logic               last;
  } cell_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [COORD_W-1:0]  center_x_i;
  logic signed [COORD_W-1:0]  center_y_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [COORD_W-1:0]  cell_x_o;
  logic signed [COORD_W-1:0]  cell_y_o;
  logic                       event_kind_o;
  logic                       last_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [2:0]                 paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  // Expected cells in emission order, and the tracker state behind them.
  cell_t              cell_q[$];
  cell_t              want_cell;
  logic [1:0]         cfg_range;
  logic [COORD_W-1:0] prev_cx;
  logic [COORD_W-1:0] prev_cy;
  logic [1:0]         prev_r;
  logic               prev_valid;

  int  fail_count;
  int  send_idle_pct;
  int  stall_pct;
  int  quiet_cycles;
  bit  watchdog_on;

  manhattan_neighborhood_diff dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .center_x_i   (center_x_i),
    .center_y_i   (center_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_x_o     (cell_x_o),
    .cell_y_o     (cell_y_o),
    .event_kind_o (event_kind_o),
    .last_o       (last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock with a 20 ns period.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  // Magnitude of the shortest signed difference on the wrapped grid.
  function automatic int unsigned wrap_dist(input logic [COORD_W-1:0] a,
                                            input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] d;
    d = a - b;
    if (d[COORD_W-1]) begin
      d = -d;
    end
    return int'(d);
  endfunction

  function automatic bit covers(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                                input int unsigned r);
    return (wrap_dist(x, cx) + wrap_dist(y, cy)) <= r;
  endfunction

  // Work out the entered and left cells that one accepted centre causes.
  task automatic predict_cells(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
    cell_t              found[$];
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    int                 r;
    int                 p;
    if (cx == prev_cx && cy == prev_cy) begin
      return;
    end
    r = (cfg_range > MAX_RANGE) ? MAX_RANGE : int'(cfg_range);
    p = int'(prev_r);
    // New diamond first: cells outside the remembered one are entered.
    for (int dx = -r; dx <= r; dx++) begin
      for (int dy = -r; dy <= r; dy++) begin
        if ((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) <= r) begin
          x = cx + COORD_W'(dx);
          y = cy + COORD_W'(dy);
          if (!prev_valid || !covers(x, y, prev_cx, prev_cy, p)) begin
            found.push_back('{x, y, EV_ENTER, 1'b0});
          end
        end
      end
    end
    // Then the remembered diamond: cells no longer covered are left.
    if (prev_valid) begin
      for (int dx = -p; dx <= p; dx++) begin
        for (int dy = -p; dy <= p; dy++) begin
          if ((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy) <= p) begin
            x = prev_cx + COORD_W'(dx);
            y = prev_cy + COORD_W'(dy);
            if (!covers(x, y, cx, cy, r)) begin
              found.push_back('{x, y, EV_LEFT, 1'b0});
            end
          end
        end
      end
    end
    if (found.size() > 0) begin
      found[found.size()-1].last = 1'b1;
    end
    foreach (found[i]) begin
      cell_q.push_back(found[i]);
    end
    prev_cx    = cx;
    prev_cy    = cy;
    prev_r     = 2'(r);
    prev_valid = 1'b1;
  endtask

  // Send one centre, with random idle cycles ahead of it.
  task automatic send_center(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    center_x_i <= x;
    center_y_i <= y;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    predict_cells(x, y);
  endtask

  // Drop valid, wait for every expected cell, then let the block settle.
  task automatic wait_cells_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cell_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register transaction: setup cycle, then access cycle.
  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= RANGE_ADDR;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write the range register while idle and read it back.
  task automatic set_detect_range(input logic [31:0] value);
    logic [31:0] rdata;
    wait_cells_drained();
    apb_access(1'b1, value, rdata);
    cfg_range = value[1:0];
    apb_access(1'b0, 32'h0, rdata);
    if (rdata[1:0] !== cfg_range) begin
      report_mismatch("detect_range readback", rdata, 32'(cfg_range));
    end
  endtask

  // The reset centre causes nothing and the register reads its reset value.
  task automatic test_reset_centre();
    logic [31:0] rdata;
    send_center(16'sd0, 16'sd0);
    send_center(16'sd0, 16'sd0);
    wait_cells_drained();
    apb_access(1'b0, 32'h0, rdata);
    if (rdata[1:0] !== DETECT_RANGE_RESET) begin
      report_mismatch("detect_range reset value", rdata, 32'(DETECT_RANGE_RESET));
    end
  endtask

  // First move fills the diamond from an empty set; a repeat causes nothing.
  task automatic test_empty_set();
    send_center(16'sd5, -16'sd3);
    send_center(16'sd5, -16'sd3);
    send_center(16'sd6, -16'sd3);
    send_center(16'sd6, -16'sd1);
  endtask

  // A range change without a move is held until the centre next changes.
  task automatic test_range_change();
    set_detect_range(32'd0);
    send_center(16'sd6, -16'sd1);
    send_center(16'sd6, 16'sd0);
    set_detect_range(32'd3);
    send_center(16'sd6, 16'sd0);
    send_center(16'sd9, 16'sd1);
    set_detect_range(32'hFFFF_FFFD);
    send_center(16'sd8, 16'sd1);
  endtask

  // Far corners of the coordinate range at the widest diamond.
  task automatic test_extremes();
    set_detect_range(32'd3);
    send_center(16'sd32000, 16'sd32000);
    send_center(-16'sd32000, -16'sd32000);
    send_center(-16'sd32000, 16'sd32000);
    send_center(16'sd32000, -16'sd32000);
  endtask

  // Diamonds that straddle the edge of the wrapped grid.
  task automatic test_wrap();
    send_center(16'h7FFF, 16'h7FFF);
    send_center(16'h8000, 16'h8000);
    send_center(16'hFFFF, 16'h0000);
    send_center(16'h0001, 16'hFFFF);
  endtask

  // Random walk of the tracked object under one idling pattern.
  task automatic test_random_traffic(input int idle_pct, input int stall_v, input int moves);
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    int                 sel;
    int                 done_moves;
    send_idle_pct = idle_pct;
    stall_pct     = stall_v;
    for (int half = 0; half < 2; half++) begin
      set_detect_range($urandom());
      done_moves = 0;
      cx = prev_cx;
      cy = prev_cy;
      while (done_moves < moves / 2) begin
        sel = $urandom_range(99);
        if (sel < 60) begin
          cx = cx + COORD_W'($urandom_range(6) - 3);
          cy = cy + COORD_W'($urandom_range(6) - 3);
        end else if (sel < 80) begin
          cx = cx + COORD_W'($urandom_range(16) - 8);
          cy = cy + COORD_W'($urandom_range(16) - 8);
        end else if (sel < 92) begin
          cx = COORD_W'($urandom_range(64000) - 32000);
          cy = COORD_W'($urandom_range(64000) - 32000);
        end else begin
          cx = COORD_W'($urandom());
          cy = COORD_W'($urandom());
        end
        if (cx != prev_cx || cy != prev_cy) begin
          done_moves++;
        end
        send_center(cx, cy);
      end
    end
  endtask

  // Result side stall pattern.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Compare each accepted result with the oldest expected cell.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cell_q.size() == 0) begin
        report_mismatch("unexpected cell", {cell_x_o, cell_y_o}, 32'h0);
      end else begin
        want_cell = cell_q.pop_front();
        if (cell_x_o !== want_cell.x) begin
          report_mismatch("cell_x", 32'(cell_x_o), 32'(want_cell.x));
        end
        if (cell_y_o !== want_cell.y) begin
          report_mismatch("cell_y", 32'(cell_y_o), 32'(want_cell.y));
        end
        if (event_kind_o !== want_cell.kind) begin
          report_mismatch("event_kind", 32'(event_kind_o), 32'(want_cell.kind));
        end
        if (last_o !== want_cell.last) begin
          report_mismatch("last", 32'(last_o), 32'(want_cell.last));
        end
      end
    end
  end

  // End the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!watchdog_on || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    center_x_i    = '0;
    center_y_i    = '0;
    out_stall_i   = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    fail_count    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    quiet_cycles  = 0;
    watchdog_on   = 1'b0;
    cfg_range     = DETECT_RANGE_RESET;
    prev_cx       = '0;
    prev_cy       = '0;
    prev_r        = '0;
    prev_valid    = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni      <= 1'b1;
    watchdog_on = 1'b1;

    test_reset_centre();
    test_empty_set();
    test_range_change();
    test_extremes();
    test_wrap();
    test_random_traffic(0, 0, 80);
    test_random_traffic(62, 0, 80);
    test_random_traffic(0, 62, 80);
    test_random_traffic(27, 27, 80);

    wait_cells_drained();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/mnd_pkg.sv
rtl/core/mnd_queue.sv
rtl/core/mnd_front.sv
rtl/core/mnd_back.sv
rtl/core/manhattan_neighborhood_diff.sv
test/tb_manhattan_neighborhood_diff.sv
